/* sv/ssd_pkg.sv */
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared constants, types and the segment table for the two-wire
// seven-segment display driver.
// ----------------------------------------------------------------------------
package ssd_pkg;

  // number of displayed decimal digits
  localparam int NUM_DIGITS = 4;
  localparam int DIG_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int BYTE_IDX_W = $clog2(NUM_DIGITS + 1);
  // digit that carries the separator segment
  localparam int SEP_DIGIT  = NUM_DIGITS / 2 - 1;

  localparam int VALUE_W    = 32;
  localparam int BRIGHT_W   = 4;
  localparam logic [BRIGHT_W-1:0] BRIGHT_RST = 4'd8;

  // command bytes
  localparam logic [7:0] CMD_WRITE  = 8'h40;
  localparam logic [7:0] CMD_ADDR   = 8'hC0 | (8'h00 & 8'h03);
  localparam logic [7:0] CMD_BRIGHT = 8'h80;
  localparam logic [7:0] SEP_BIT    = 8'h80;

  // divide by ten: q = (v * RECIP10) >> RECIP_SHIFT, exact for 32-bit v
  localparam logic [VALUE_W-1:0] RECIP10 = 32'hCCCC_CCCD;
  localparam int RECIP_SHIFT = 35;
  localparam int PROD_W      = 2 * VALUE_W;
  localparam int QUO_W       = PROD_W - RECIP_SHIFT;

  // request queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic {
    KIND_TICK,
    KIND_REQ
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [VALUE_W-1:0] value;
    logic               separator;
  } item_t;

  // segment byte write from the digit unit
  typedef struct packed {
    logic             we;
    logic [DIG_W-1:0] idx;
    logic [7:0]       data;
  } seg_wr_t;

  // hex digit to segment code, bit 0 = segment a
  function automatic logic [7:0] seg_code(input logic [3:0] d);
    logic [7:0] c;
    case (d)
      4'h0: c = 8'h3F;
      4'h1: c = 8'h06;
      4'h2: c = 8'h5B;
      4'h3: c = 8'h4F;
      4'h4: c = 8'h66;
      4'h5: c = 8'h6D;
      4'h6: c = 8'h7D;
      4'h7: c = 8'h07;
      4'h8: c = 8'h7F;
      4'h9: c = 8'h6F;
      4'hA: c = 8'h77;
      4'hB: c = 8'h7C;
      4'hC: c = 8'h39;
      4'hD: c = 8'h5E;
      4'hE: c = 8'h79;
      4'hF: c = 8'h71;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* sv/ssd_in_if.sv */
// ----------------------------------------------------------------------------
// ssd_in_if
// Request channel: a phase tick or a new display request.
// ----------------------------------------------------------------------------
interface ssd_in_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [ssd_pkg::VALUE_W-1:0]  value;
  logic                         separator;

  modport source (output valid, mode, value, separator, input ready);
  modport sink   (input valid, mode, value, separator, output ready);
endinterface

/* sv/ssd_out_if.sv */
// ----------------------------------------------------------------------------
// ssd_out_if
// Result channel: pin levels, busy and dropped flags after each request.
// ----------------------------------------------------------------------------
interface ssd_out_if;
  logic valid;
  logic ready;
  logic clk_level;
  logic dio_level;
  logic busy_res;
  logic dropped;

  modport source (output valid, clk_level, dio_level, busy_res, dropped, input ready);
  modport sink   (input valid, clk_level, dio_level, busy_res, dropped, output ready);
endinterface

/* sv/ssd_front.sv */
// ----------------------------------------------------------------------------
// ssd_front
// Accepts requests, tags each as tick or display request and holds them
// in a short queue for the sequencer.
// ----------------------------------------------------------------------------
module ssd_front (
  input  logic              clk,
  input  logic              rst_n,
  ssd_in_if.sink            in_ch,
  output ssd_pkg::item_t    q_item,
  output logic              q_valid,
  input  logic              q_ready
);

  ssd_pkg::item_t                  mem_r [ssd_pkg::QDEPTH];
  logic [ssd_pkg::QPTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [ssd_pkg::QCNT_W-1:0]      cnt_r;
  logic                            push, pop;
  ssd_pkg::item_t                  new_item;

  // classify the incoming request
  always_comb begin
    new_item.kind      = in_ch.mode ? ssd_pkg::KIND_REQ : ssd_pkg::KIND_TICK;
    new_item.value     = in_ch.value;
    new_item.separator = in_ch.separator;
  end

  assign in_ch.ready = (cnt_r != ssd_pkg::QCNT_W'(ssd_pkg::QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != '0);
  assign pop         = q_valid && q_ready;
  assign q_item      = mem_r[rd_ptr_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_item;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == ssd_pkg::QPTR_W'(ssd_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == ssd_pkg::QPTR_W'(ssd_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

/* sv/ssd_digits.sv */
// ----------------------------------------------------------------------------
// ssd_digits
// Splits the value into decimal digits, least significant first (multiply by
// reciprocal, then remainder), and writes the segment code of each digit.
// ----------------------------------------------------------------------------
module ssd_digits (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ssd_pkg::VALUE_W-1:0]   value,
  input  logic                          separator,
  output ssd_pkg::seg_wr_t              seg_wr
);

  logic                           busy_r;
  logic                           mul_r;
  logic [ssd_pkg::VALUE_W-1:0]    val_r;
  logic [ssd_pkg::PROD_W-1:0]     prod_r;
  logic [ssd_pkg::DIG_W-1:0]      idx_r;
  logic                           sep_r;

  logic [ssd_pkg::PROD_W-1:0]     prod;
  logic [ssd_pkg::VALUE_W-1:0]    quo;
  logic [ssd_pkg::VALUE_W-1:0]    quo10;
  logic [ssd_pkg::VALUE_W-1:0]    rem;
  logic [7:0]                     code;

  // reciprocal multiply
  assign prod = ssd_pkg::PROD_W'(val_r) * ssd_pkg::PROD_W'(ssd_pkg::RECIP10);

  // quotient, remainder and segment code
  always_comb begin
    quo   = ssd_pkg::VALUE_W'(prod_r[ssd_pkg::PROD_W-1:ssd_pkg::RECIP_SHIFT]);
    quo10 = (quo << 3) + (quo << 1);
    rem   = val_r - quo10;
    code  = ssd_pkg::seg_code(rem[3:0]);
    if (sep_r && (idx_r == ssd_pkg::DIG_W'(ssd_pkg::SEP_DIGIT))) begin
      code = code | ssd_pkg::SEP_BIT;
    end
  end

  always_comb begin
    seg_wr.we   = busy_r && mul_r;
    seg_wr.idx  = idx_r;
    seg_wr.data = code;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      val_r <= value;
      idx_r <= ssd_pkg::DIG_W'(ssd_pkg::NUM_DIGITS - 1);
      sep_r <= separator;
    end else if (busy_r) begin
      if (!mul_r) begin
        prod_r <= prod;
      end else begin
        val_r <= quo;
        idx_r <= idx_r - 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      mul_r  <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      mul_r  <= 1'b0;
    end else if (busy_r) begin
      mul_r <= !mul_r;
      if (mul_r && (idx_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

endmodule

/* sv/ssd_back.sv */
// ----------------------------------------------------------------------------
// ssd_back
// Phase sequencer: takes one queued request per cycle unless out_ch stalls,
// drives the clock and data pins through three frames, registers the result.
// ----------------------------------------------------------------------------
module ssd_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ssd_pkg::item_t                 q_item,
  input  logic                           q_valid,
  output logic                           q_ready,
  input  logic                           cfg_we,
  input  logic [ssd_pkg::BRIGHT_W-1:0]   cfg_wdata,
  output logic                           dig_start,
  input  ssd_pkg::seg_wr_t               seg_wr,
  ssd_out_if.source                      out_ch
);

  typedef enum logic [1:0] {
    FR_CMD,
    FR_DATA,
    FR_CTRL
  } frame_t;

  typedef enum logic [1:0] {
    P_START,
    P_BYTE,
    P_ACK,
    P_STOP
  } part_t;

  frame_t                             frame_r, frame_nxt;
  part_t                              part_r, part_nxt;
  logic [ssd_pkg::BYTE_IDX_W-1:0]     byte_r, byte_nxt;
  logic [2:0]                         bit_r, bit_nxt;
  logic [1:0]                         sub_r, sub_nxt;
  logic                               active_r, active_nxt;
  logic                               clk_pin_r, clk_pin_nxt;
  logic                               dio_pin_r, dio_pin_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic                               busy_out_r, busy_out_nxt;
  logic                               drop_out_r, drop_out_nxt;
  logic [ssd_pkg::BRIGHT_W-1:0]       bright_r;
  logic [7:0]                         seg_r [ssd_pkg::NUM_DIGITS];

  logic                               take;
  logic [ssd_pkg::BYTE_IDX_W-1:0]     seg_sel;
  logic [7:0]                         cur_byte;
  logic [ssd_pkg::BYTE_IDX_W-1:0]     last_byte;

  assign q_ready = !out_valid_r || out_ch.ready;
  assign take    = q_valid && q_ready;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.clk_level = clk_pin_r;
  assign out_ch.dio_level = dio_pin_r;
  assign out_ch.busy_res  = busy_out_r;
  assign out_ch.dropped   = drop_out_r;

  // byte being sent
  assign seg_sel = byte_r - 1'b1;
  always_comb begin
    case (frame_r)
      FR_CMD:  cur_byte = ssd_pkg::CMD_WRITE;
      FR_DATA: cur_byte = (byte_r == '0) ? ssd_pkg::CMD_ADDR
                                         : seg_r[seg_sel[ssd_pkg::DIG_W-1:0]];
      FR_CTRL: cur_byte = ssd_pkg::CMD_BRIGHT | 8'(bright_r);
      default: cur_byte = 8'h00;
    endcase
    last_byte = (frame_r == FR_DATA) ? ssd_pkg::BYTE_IDX_W'(ssd_pkg::NUM_DIGITS) : '0;
  end

  // sequencer next state
  always_comb begin
    frame_nxt     = frame_r;
    part_nxt      = part_r;
    byte_nxt      = byte_r;
    bit_nxt       = bit_r;
    sub_nxt       = sub_r;
    active_nxt    = active_r;
    clk_pin_nxt   = clk_pin_r;
    dio_pin_nxt   = dio_pin_r;
    out_valid_nxt = out_valid_r;
    busy_out_nxt  = busy_out_r;
    drop_out_nxt  = drop_out_r;
    dig_start     = 1'b0;

    if (take) begin
      drop_out_nxt = 1'b0;
      if (q_item.kind == ssd_pkg::KIND_REQ) begin
        if (active_r) begin
          drop_out_nxt = 1'b1;
        end else begin
          // arm a new transfer
          active_nxt = 1'b1;
          dig_start  = 1'b1;
          frame_nxt  = FR_CMD;
          part_nxt   = P_START;
          byte_nxt   = '0;
          bit_nxt    = '0;
          sub_nxt    = '0;
        end
      end else if (active_r) begin
        case (part_r)
          P_START: begin
            dio_pin_nxt = 1'b0;
            part_nxt    = P_BYTE;
            byte_nxt    = '0;
            bit_nxt     = '0;
            sub_nxt     = '0;
          end
          P_BYTE: begin
            // clock low, data bit, clock high
            case (sub_r)
              2'd0:    clk_pin_nxt = 1'b0;
              2'd1:    dio_pin_nxt = cur_byte[bit_r];
              default: clk_pin_nxt = 1'b1;
            endcase
            if (sub_r == 2'd2) begin
              sub_nxt = '0;
              if (bit_r == 3'd7) begin
                part_nxt = P_ACK;
              end else begin
                bit_nxt = bit_r + 1'b1;
              end
            end else begin
              sub_nxt = sub_r + 1'b1;
            end
          end
          P_ACK: begin
            // dummy acknowledge, never sampled
            case (sub_r)
              2'd0: begin
                clk_pin_nxt = 1'b0;
                dio_pin_nxt = 1'b1;
              end
              2'd1:    clk_pin_nxt = 1'b1;
              2'd2:    dio_pin_nxt = 1'b0;
              default: clk_pin_nxt = 1'b0;
            endcase
            sub_nxt = sub_r + 1'b1;
            if (sub_r == 2'd3) begin
              bit_nxt = '0;
              if (byte_r == last_byte) begin
                part_nxt = P_STOP;
              end else begin
                part_nxt = P_BYTE;
                byte_nxt = byte_r + 1'b1;
              end
            end
          end
          default: begin
            // stop: data low, clock high, data high
            case (sub_r)
              2'd0:    dio_pin_nxt = 1'b0;
              2'd1:    clk_pin_nxt = 1'b1;
              default: dio_pin_nxt = 1'b1;
            endcase
            if (sub_r == 2'd2) begin
              sub_nxt  = '0;
              part_nxt = P_START;
              case (frame_r)
                FR_CMD:  frame_nxt = FR_DATA;
                FR_DATA: frame_nxt = FR_CTRL;
                default: begin
                  frame_nxt  = FR_CMD;
                  active_nxt = 1'b0;
                end
              endcase
            end else begin
              sub_nxt = sub_r + 1'b1;
            end
          end
        endcase
      end
      out_valid_nxt = 1'b1;
      busy_out_nxt  = active_nxt;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r     <= FR_CMD;
      part_r      <= P_START;
      byte_r      <= '0;
      bit_r       <= '0;
      sub_r       <= '0;
      active_r    <= 1'b0;
      clk_pin_r   <= 1'b0;
      dio_pin_r   <= 1'b0;
      out_valid_r <= 1'b0;
      busy_out_r  <= 1'b0;
      drop_out_r  <= 1'b0;
      bright_r    <= ssd_pkg::BRIGHT_RST;
    end else begin
      frame_r     <= frame_nxt;
      part_r      <= part_nxt;
      byte_r      <= byte_nxt;
      bit_r       <= bit_nxt;
      sub_r       <= sub_nxt;
      active_r    <= active_nxt;
      clk_pin_r   <= clk_pin_nxt;
      dio_pin_r   <= dio_pin_nxt;
      out_valid_r <= out_valid_nxt;
      busy_out_r  <= busy_out_nxt;
      drop_out_r  <= drop_out_nxt;
      if (cfg_we) begin
        bright_r <= cfg_wdata;
      end
    end
  end

  // segment byte store, filled by the digit unit
  always_ff @(posedge clk) begin
    if (seg_wr.we) begin
      seg_r[seg_wr.idx] <= seg_wr.data;
    end
  end

endmodule

/* sv/seven_segment_serial_display_driver.sv */
// ----------------------------------------------------------------------------
// seven_segment_serial_display_driver
// Two-wire seven-segment display driver: converts a value to four segment
// bytes and sends three command frames, one pin phase per tick request.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  in_ch     in   valid/ready    mode, value[31:0], separator
//  out_ch    out  valid/ready    clk_level, dio_level, busy_res, dropped
//  cfg       in   cfg_we         cfg_wdata[3:0] = brightness
//
//  one request per cycle sustained while out_ch takes each result; each request
//  gives one result, registered in the queue and then in the sequencer register.
//  a display request starts the digit unit, which finds each digit by a
//  reciprocal multiply and then a remainder; the bytes are ready long before
//  the first data byte goes out.
//  reset (rst_n low, synchronous) leaves the block idle, pins low, brightness 8.
//  a two-entry queue takes up to two requests while a result waits on out_ch.
// ----------------------------------------------------------------------------
module seven_segment_serial_display_driver (
  input  logic                          clk,
  input  logic                          rst_n,
  ssd_in_if.sink                        in_ch,
  ssd_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [ssd_pkg::BRIGHT_W-1:0]  cfg_wdata
);

  ssd_pkg::item_t    q_item;
  logic              q_valid;
  logic              q_ready;
  logic              dig_start;
  ssd_pkg::seg_wr_t  seg_wr;

  // accept and queue requests
  ssd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_ready (q_ready)
  );

  // decimal digits to segment codes
  ssd_digits u_digits (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (dig_start),
    .value     (q_item.value),
    .separator (q_item.separator),
    .seg_wr    (seg_wr)
  );

  // pin phase sequencer and result register
  ssd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_item    (q_item),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .dig_start (dig_start),
    .seg_wr    (seg_wr),
    .out_ch    (out_ch)
  );

endmodule
